>>> rtl/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants for the natural log series block
// Fixed-point formats of the divider and the series stages, and the
// series coefficients 1/k in Q.30.
// ----------------------------------------------------------------------------
package nls_pkg;

   localparam int unsigned QF       = 30;
   localparam int unsigned X_W      = 32;
   localparam int unsigned DEN_W    = X_W + 1;
   localparam int unsigned QUO_W    = QF + 1;
   localparam int unsigned P_W      = 31;
   localparam int unsigned LOG_W    = 28;
   localparam int unsigned N_HORNER = 6;

   // divider state carried from stage to stage
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] dlow;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             neg;
   } div_type;

   // series state carried through the Horner stages
   typedef struct packed {
      logic [QUO_W-1:0] c;
      logic [QUO_W-1:0] c2;
      logic [P_W-1:0]   p;
      logic             neg;
   } ser_type;

   typedef logic [P_W-1:0] coef_array_type [0:N_HORNER];

   // round(2^30 / k) for k = 1, 3, ..., 13
   localparam coef_array_type COEF = '{
      31'd1073741824, 31'd357913941, 31'd214748365, 31'd153391689,
      31'd119304647,  31'd97612893,  31'd82595525
   };

endpackage

>>> rtl/nls_div_stage.sv
// ----------------------------------------------------------------------------
// nls_div_stage: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// where it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module nls_div_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  nls_pkg::div_type in_data,
   output logic            out_valid,
   output nls_pkg::div_type out_data
);

   logic             valid_ff;
   nls_pkg::div_type data_ff;
   nls_pkg::div_type data_in;
   logic [nls_pkg::DEN_W:0] trial;
   logic                    fits;

   // shift in next dividend bit and try the subtraction
   always_comb begin
      trial = {in_data.rem, in_data.dlow[nls_pkg::QUO_W-1]};
      fits  = trial >= {1'b0, in_data.den};
      data_in      = in_data;
      data_in.rem  = fits ? nls_pkg::DEN_W'(trial - {1'b0, in_data.den})
                          : nls_pkg::DEN_W'(trial);
      data_in.dlow = {in_data.dlow[nls_pkg::QUO_W-2:0], 1'b0};
      data_in.quo  = {in_data.quo[nls_pkg::QUO_W-2:0], fits};
   end

   // advance when the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/nls_horner_stage.sv
// ----------------------------------------------------------------------------
// nls_horner_stage: one Horner step of the series polynomial
// Forms p * c^2 rounded to Q.30 and adds the next coefficient.
// ----------------------------------------------------------------------------
module nls_horner_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [nls_pkg::P_W-1:0]       coef_value,
   input  logic                          in_valid,
   input  nls_pkg::ser_type              in_data,
   output logic                          out_valid,
   output nls_pkg::ser_type              out_data
);

   localparam int unsigned PROD_W = nls_pkg::P_W + nls_pkg::QUO_W;

   logic              valid_ff;
   nls_pkg::ser_type  data_ff;
   nls_pkg::ser_type  data_in;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_rnd;

   // multiply, round to Q.30 and add the coefficient
   always_comb begin
      prod     = PROD_W'(in_data.p) * PROD_W'(in_data.c2);
      prod_rnd = prod + (PROD_W'(1) << (nls_pkg::QF - 1));
      data_in   = in_data;
      data_in.p = nls_pkg::P_W'(prod_rnd >> nls_pkg::QF) + coef_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/natural_log_series.sv
// ----------------------------------------------------------------------------
// natural_log_series: ln(x) by the seven-term atanh series
// Pipelined divider for c = (x-1)/(x+1) followed by a Horner evaluation of
// the series in c^2 and a final scaling by 2c.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: req_x_value, unsigned with IN_FRAC_BITS fraction bits,
//   taken when req_valid is high and req_stall is low.
//   Result beat: rsp_log_value, signed with OUT_FRAC_BITS fraction bits,
//   delivered when rsp_valid is high and rsp_stall is low.
//   From input beat to result beat the pipeline has one set-up
//   stage, 31 divider stages (one quotient bit each), one c^2 stage, six
//   Horner stages, one product stage and the output register.
//   Throughput is one beat per cycle unless stalled; the divider chain sets the depth.
//   While the output register holds an untaken beat and rsp_stall is high,
//   the whole pipeline holds and req_stall is raised; no beat is lost or
//   repeated. Reset empties the pipeline; there is no other state.
// ----------------------------------------------------------------------------
module natural_log_series #(
   parameter int unsigned IN_FRAC_BITS  = 16,
   parameter int unsigned OUT_FRAC_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nls_pkg::X_W-1:0]       req_x_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [nls_pkg::LOG_W-1:0] rsp_log_value
);

   localparam int unsigned QW     = nls_pkg::QUO_W;
   localparam int unsigned DW     = nls_pkg::DEN_W;
   localparam int unsigned DIV_W  = nls_pkg::X_W + nls_pkg::QF + 1;
   localparam int unsigned FP_W   = QW + nls_pkg::P_W;
   localparam int unsigned SH     = 2 * nls_pkg::QF - 1 - OUT_FRAC_BITS;

   logic adv;

   // hold everything while an untaken result waits under stall
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // set-up: sign, |x-1|, x+1 and the rounded dividend
   logic [DW-1:0]    one;
   logic [DW-1:0]    xw;
   logic [DW-1:0]    num;
   logic [DIV_W-1:0] dvd;
   nls_pkg::div_type s0_in;
   nls_pkg::div_type s0_ff;
   logic             s0_valid_ff;

   always_comb begin
      one = DW'(1) << IN_FRAC_BITS;
      xw  = DW'(req_x_value);
      s0_in.neg = xw < one;
      num       = s0_in.neg ? (one - xw) : (xw - one);
      s0_in.den = xw + one;
      dvd = (DIV_W'(num) << nls_pkg::QF) + DIV_W'(s0_in.den >> 1);
      s0_in.rem  = DW'(dvd[DIV_W-1:QW]);
      s0_in.dlow = dvd[QW-1:0];
      s0_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   // divider chain, one quotient bit per stage
   logic             dv_valid [0:QW];
   nls_pkg::div_type dv_data  [0:QW];

   assign dv_valid[0] = s0_valid_ff;
   assign dv_data[0]  = s0_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      nls_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   // square c and load the top coefficient
   localparam int unsigned SQ_W = 2 * QW;
   logic [SQ_W-1:0]  sq;
   nls_pkg::ser_type sq_in;
   nls_pkg::ser_type sq_ff;
   logic             sq_valid_ff;

   always_comb begin
      sq = SQ_W'(dv_data[QW].quo) * SQ_W'(dv_data[QW].quo)
         + (SQ_W'(1) << (nls_pkg::QF - 1));
      sq_in.c   = dv_data[QW].quo;
      sq_in.c2  = QW'(sq >> nls_pkg::QF);
      sq_in.p   = nls_pkg::COEF[nls_pkg::N_HORNER];
      sq_in.neg = dv_data[QW].neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff <= dv_valid[QW];
      end
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // Horner chain from the 1/11 term down to the unit term
   logic             hs_valid [0:nls_pkg::N_HORNER];
   nls_pkg::ser_type hs_data  [0:nls_pkg::N_HORNER];

   assign hs_valid[0] = sq_valid_ff;
   assign hs_data[0]  = sq_ff;

   for (genvar j = 0; j < nls_pkg::N_HORNER; j++) begin : g_horner
      nls_horner_stage u_horner (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .coef_value (nls_pkg::COEF[nls_pkg::N_HORNER-1-j]),
         .in_valid   (hs_valid[j]),
         .in_data    (hs_data[j]),
         .out_valid  (hs_valid[j+1]),
         .out_data   (hs_data[j+1])
      );
   end

   // final product c * p
   logic [FP_W-1:0] fp_ff;
   logic            fp_neg_ff;
   logic            fp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_valid_ff <= 1'b0;
      end else if (adv) begin
         fp_valid_ff <= hs_valid[nls_pkg::N_HORNER];
      end
      if (adv) begin
         fp_ff     <= FP_W'(hs_data[nls_pkg::N_HORNER].c)
                    * FP_W'(hs_data[nls_pkg::N_HORNER].p);
         fp_neg_ff <= hs_data[nls_pkg::N_HORNER].neg;
      end
   end

   // round to the output format and apply the sign
   logic [FP_W:0]               fr;
   logic [nls_pkg::LOG_W-1:0]   mag;
   logic [nls_pkg::LOG_W-1:0]   res_in;
   logic [nls_pkg::LOG_W-1:0]   res_ff;
   logic                        res_valid_ff;

   always_comb begin
      fr     = {1'b0, fp_ff} + ((FP_W + 1)'(1) << (SH - 1));
      mag    = nls_pkg::LOG_W'(fr >> SH);
      res_in = fp_neg_ff ? (nls_pkg::LOG_W'(0) - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (adv) begin
         res_valid_ff <= fp_valid_ff;
      end
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid     = res_valid_ff;
   assign rsp_log_value = $signed(res_ff);

endmodule
